// ===== src/zud_pkg.sv =====
// shared constants, types and helper functions for the zip reduce decoder
`default_nettype none

package zud_pkg;

    localparam int WINDOW_SIZE_DEF = 16384;
    localparam int OUT_LANES_DEF   = 8;
    localparam int MAX_LANES       = 8;
    localparam int FOLLOW_AW       = 6;
    localparam int FOLLOW_DEPTH    = 256 * (2 ** FOLLOW_AW);

    localparam logic [7:0] DLE_CODE = 8'd144;

    // configuration register indexes
    localparam logic CFG_FACTOR   = 1'b0;
    localparam logic CFG_OUT_SIZE = 1'b1;

    // stream phases
    typedef enum logic [1:0] {
        PH_COUNT  = 2'd0,
        PH_FOLLOW = 2'd1,
        PH_DECODE = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // request from the sequencer to the lane packer
    typedef struct packed {
        logic       push;
        logic       flush;
        logic [7:0] data;
        logic       done;
    } pk_req_t;

    // out of range factors fold to the nearest legal one
    function automatic logic [2:0] factor_clamp(input logic [2:0] r);
        logic [2:0] f;
        begin
            if (r == 3'd0)
                f = 3'd1;
            else if (r > 3'd4)
                f = 3'd4;
            else
                f = r;
            return f;
        end
    endfunction

    function automatic logic [7:0] len_mask(input logic [2:0] f);
        logic [7:0] m;
        begin
            unique case (f)
                3'd1:    m = 8'h7f;
                3'd2:    m = 8'h3f;
                3'd3:    m = 8'h1f;
                default: m = 8'h0f;
            endcase
            return m;
        end
    endfunction

    function automatic logic [3:0] dist_shift(input logic [2:0] f);
        logic [3:0] s;
        begin
            unique case (f)
                3'd1:    s = 4'd7;
                3'd2:    s = 4'd6;
                3'd3:    s = 4'd5;
                default: s = 4'd4;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] dist_mask(input logic [2:0] f);
        logic [3:0] m;
        begin
            unique case (f)
                3'd1:    m = 4'h1;
                3'd2:    m = 4'h3;
                3'd3:    m = 4'h7;
                default: m = 4'hf;
            endcase
            return m;
        end
    endfunction

    // width of a follower index, at least one bit
    function automatic logic [3:0] index_bits(input logic [5:0] cnt);
        logic [3:0] b;
        begin
            b = 4'd1;
            for (int i = 1; i < 8; i++) begin
                if ((9'd1 << i) < {3'b000, cnt})
                    b = 4'(i + 1);
            end
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/zip_unreduce_decoder_top.sv =====
// zip reduce decoder: bit sequencer, table and window memories, lane packer
//
// Input channel s_*: one compressed bit per transfer in s_tdata[0], lsb-first
// stream order; s_tuser high restarts the stream (follower tables reload,
// window starts a fresh pass, out_size is taken as the byte budget).
// Output channel m_*: up to eight decoded bytes per transfer with a count;
// m_tlast marks the last transfer caused by one input bit, m_tuser marks
// the transfer holding the final byte of out_size.
// cfg_*: register 0 is the reduce factor, register 1 the output size;
// write only while the block is idle.
// A symbol that comes from a follower set takes an extra pass through the
// table read state S_TBL. A match copy runs through the history window
// memory a byte at a time, since each byte is read in S_CRD and written back
// in S_CWR before the next read.
// s_tready is high only while the sequencer is idle. A stalled receiver
// holds the output register, and the sequencer waits on the packer.
// Reset clears all control state; the memories keep their contents and
// need no clearing pass.
`default_nettype none

module zip_unreduce_decoder_top #(
    parameter int WINDOW_SIZE = zud_pkg::WINDOW_SIZE_DEF,
    parameter int OUT_LANES   = zud_pkg::OUT_LANES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // stream_bit, zero pad
    input  wire         s_tuser,   // restart
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // byte0..byte7, byte_count, zero pad
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // stream_done
    input  wire         cfg_we,
    input  wire         cfg_addr,
    input  wire  [31:0] cfg_data
);
    import zud_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [AW:0] WIN = (AW + 1)'(WINDOW_SIZE);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PROC  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_TBL   = 8'b0000_1000,
        S_EXP   = 8'b0001_0000,
        S_CRD   = 8'b0010_0000,
        S_CWR   = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [7:0]    load_char_reg, load_char_next;
    logic [5:0]    load_index_reg, load_index_next;
    logic [5:0]    cur_cnt_reg, cur_cnt_next;
    logic [7:0]    acc_reg, acc_next;
    logic [3:0]    bc_reg, bc_next;
    logic [1:0]    sp_reg, sp_next;
    logic [7:0]    prev_reg, prev_next;
    logic [1:0]    es_reg, es_next;
    logic [7:0]    cv_reg, cv_next;
    logic [8:0]    ml_reg, ml_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          fp_reg, fp_next;
    logic [31:0]   bl_reg, bl_next;
    logic [7:0]    sym_reg, sym_next;
    logic [AW-1:0] src_reg, src_next;
    logic [8:0]    n_reg, n_next;
    logic          bit_reg, bit_next;
    logic [2:0]    factor_reg;
    logic [31:0]   out_size_reg;

    logic [7:0]    acc_new;
    logic [3:0]    bc_new;
    logic [2:0]    fac;
    logic [7:0]    lmask;
    logic [12:0]   copy_dist;
    logic [AW:0]   dist_mod;
    logic [1:0]    sp_eff;
    logic [3:0]    need;
    logic [7:0]    copy_byte;

    logic          fc_we;
    logic [5:0]    fc_rdata;
    logic          ft_we;
    logic [7:0]    ft_rdata;
    logic [7:0]    hist_rdata;
    logic          push_fire;
    pk_req_t       req;
    logic          pk_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            factor_reg   <= 3'd1;
            out_size_reg <= 32'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FACTOR:   factor_reg   <= cfg_data[2:0];
                CFG_OUT_SIZE: out_size_reg <= cfg_data;
                default:      factor_reg   <= factor_reg;
            endcase
        end
    end

    // shared datapath terms
    assign acc_new  = acc_reg | (8'(bit_reg) << bc_reg[2:0]);
    assign bc_new   = bc_reg + 4'd1;
    assign fac      = factor_clamp(factor_reg);
    assign lmask    = len_mask(fac);
    // distance: high bits of the code above the low byte, plus one
    assign copy_dist = {1'b0, 4'((cv_reg >> dist_shift(fac)) & {4'h0, dist_mask(fac)}), 8'h00}
                       + {5'd0, sym_reg} + 13'd1;
    assign dist_mod = ((AW + 1)'(copy_dist) == WIN) ? '0 : (AW + 1)'(copy_dist);
    assign sp_eff   = (sp_reg == 2'd0) ? 2'd1 : sp_reg;
    assign need     = (sp_eff == 2'd1) ? 4'd8 : index_bits(fc_rdata);
    assign copy_byte = (fp_reg && (wp_reg <= src_reg)) ? 8'd0 : hist_rdata;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        load_char_next  = load_char_reg;
        load_index_next = load_index_reg;
        cur_cnt_next    = cur_cnt_reg;
        acc_next        = acc_reg;
        bc_next         = bc_reg;
        sp_next         = sp_reg;
        prev_next       = prev_reg;
        es_next         = es_reg;
        cv_next         = cv_reg;
        ml_next         = ml_reg;
        wp_next         = wp_reg;
        fp_next         = fp_reg;
        bl_next         = bl_reg;
        sym_next        = sym_reg;
        src_next        = src_reg;
        n_next          = n_reg;
        bit_next        = bit_reg;
        fc_we           = 1'b0;
        ft_we           = 1'b0;
        req             = '0;
        req.done        = (bl_reg == 32'd0);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    bit_next   = s_tdata[0];
                    state_next = S_PROC;
                    if (s_tuser) begin
                        phase_next      = PH_COUNT;
                        load_char_next  = 8'd255;
                        load_index_next = 6'd0;
                        acc_next        = 8'd0;
                        bc_next         = 4'd0;
                        sp_next         = 2'd0;
                        prev_next       = 8'd0;
                        es_next         = 2'd0;
                        cv_next         = 8'd0;
                        ml_next         = 9'd0;
                        wp_next         = '0;
                        fp_next         = 1'b1;
                        bl_next         = out_size_reg;
                    end
                end
            end

            S_PROC: begin
                state_next = S_IDLE;
                unique case (phase_reg)
                    PH_COUNT: begin
                        acc_next = acc_new;
                        bc_next  = bc_new;
                        if (bc_new >= 4'd6) begin
                            fc_we        = 1'b1;
                            cur_cnt_next = acc_new[5:0];
                            acc_next     = 8'd0;
                            bc_next      = 4'd0;
                            if (acc_new[5:0] == 6'd0) begin
                                if (load_char_reg == 8'd0)
                                    phase_next = (bl_reg == 32'd0) ? PH_DONE : PH_DECODE;
                                else
                                    load_char_next = load_char_reg - 8'd1;
                            end else begin
                                load_index_next = 6'd0;
                                phase_next      = PH_FOLLOW;
                            end
                        end
                    end
                    PH_FOLLOW: begin
                        acc_next = acc_new;
                        bc_next  = bc_new;
                        if (bc_new >= 4'd8) begin
                            ft_we           = 1'b1;
                            acc_next        = 8'd0;
                            bc_next         = 4'd0;
                            load_index_next = load_index_reg + 6'd1;
                            if ({1'b0, load_index_reg} + 7'd1 >= {1'b0, cur_cnt_reg}) begin
                                if (load_char_reg == 8'd0) begin
                                    phase_next = (bl_reg == 32'd0) ? PH_DONE : PH_DECODE;
                                end else begin
                                    load_char_next = load_char_reg - 8'd1;
                                    phase_next     = PH_COUNT;
                                end
                            end
                        end
                    end
                    PH_DECODE: state_next = S_DEC;
                    default:   state_next = S_IDLE;
                endcase
            end

            S_DEC: begin
                state_next = S_IDLE;
                if ((sp_reg == 2'd0) && (fc_rdata != 6'd0)) begin
                    sp_next = bit_reg ? 2'd1 : 2'd2;
                end else if (bc_new >= need) begin
                    acc_next = 8'd0;
                    bc_next  = 4'd0;
                    sp_next  = 2'd0;
                    if (sp_eff == 2'd1) begin
                        sym_next   = acc_new;
                        state_next = S_EXP;
                    end else begin
                        state_next = S_TBL;
                    end
                end else begin
                    acc_next = acc_new;
                    bc_next  = bc_new;
                    sp_next  = sp_eff;
                end
            end

            S_TBL: begin
                sym_next   = ft_rdata;
                state_next = S_EXP;
            end

            S_EXP: begin
                unique case (es_reg)
                    2'd0: begin
                        if (sym_reg != DLE_CODE) begin
                            req.push = 1'b1;
                            req.data = sym_reg;
                            if (pk_ready) begin
                                prev_next  = sym_reg;
                                state_next = S_FLUSH;
                            end
                        end else begin
                            es_next    = 2'd1;
                            prev_next  = sym_reg;
                            state_next = S_FLUSH;
                        end
                    end
                    2'd1: begin
                        if (sym_reg != 8'd0) begin
                            cv_next    = sym_reg;
                            ml_next    = {1'b0, sym_reg & lmask};
                            es_next    = ((sym_reg & lmask) == lmask) ? 2'd2 : 2'd3;
                            prev_next  = sym_reg;
                            state_next = S_FLUSH;
                        end else begin
                            req.push = 1'b1;
                            req.data = DLE_CODE;
                            if (pk_ready) begin
                                es_next    = 2'd0;
                                prev_next  = sym_reg;
                                state_next = S_FLUSH;
                            end
                        end
                    end
                    2'd2: begin
                        ml_next    = ml_reg + {1'b0, sym_reg};
                        es_next    = 2'd3;
                        prev_next  = sym_reg;
                        state_next = S_FLUSH;
                    end
                    default: begin
                        n_next = ml_reg + 9'd3;
                        if ({1'b0, wp_reg} >= dist_mod)
                            src_next = wp_reg - dist_mod[AW-1:0];
                        else
                            src_next = AW'({1'b0, wp_reg} + WIN - dist_mod);
                        es_next    = 2'd0;
                        prev_next  = sym_reg;
                        state_next = S_CRD;
                    end
                endcase
            end

            S_CRD: state_next = S_CWR;

            S_CWR: begin
                req.push = 1'b1;
                req.data = copy_byte;
                if (pk_ready) begin
                    n_next   = n_reg - 9'd1;
                    src_next = (({1'b0, src_reg} + (AW + 1)'(1)) == WIN) ? '0
                               : src_reg + AW'(1);
                    if ((n_reg == 9'd1) || (bl_reg == 32'd1))
                        state_next = S_FLUSH;
                    else
                        state_next = S_CRD;
                end
            end

            S_FLUSH: begin
                req.flush = 1'b1;
                if (pk_ready)
                    state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase

        // byte output: window write, position and budget update
        if (push_fire) begin
            fp_next = fp_reg;
            if (({1'b0, wp_reg} + (AW + 1)'(1)) == WIN) begin
                wp_next = '0;
                fp_next = 1'b0;
            end else begin
                wp_next = wp_reg + AW'(1);
            end
            bl_next = bl_reg - 32'd1;
            if (bl_reg == 32'd1)
                phase_next = PH_DONE;
        end
    end

    assign push_fire = req.push && pk_ready && (bl_reg != 32'd0);
    assign s_tready  = (state_reg == S_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_COUNT;
            load_char_reg  <= 8'd255;
            load_index_reg <= 6'd0;
            cur_cnt_reg    <= 6'd0;
            acc_reg        <= 8'd0;
            bc_reg         <= 4'd0;
            sp_reg         <= 2'd0;
            prev_reg       <= 8'd0;
            es_reg         <= 2'd0;
            cv_reg         <= 8'd0;
            ml_reg         <= 9'd0;
            wp_reg         <= '0;
            fp_reg         <= 1'b1;
            bl_reg         <= 32'd0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            load_char_reg  <= load_char_next;
            load_index_reg <= load_index_next;
            cur_cnt_reg    <= cur_cnt_next;
            acc_reg        <= acc_next;
            bc_reg         <= bc_next;
            sp_reg         <= sp_next;
            prev_reg       <= prev_next;
            es_reg         <= es_next;
            cv_reg         <= cv_next;
            ml_reg         <= ml_next;
            wp_reg         <= wp_next;
            fp_reg         <= fp_next;
            bl_reg         <= bl_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        src_reg <= src_next;
        n_reg   <= n_next;
        bit_reg <= bit_next;
    end

    // follower counts, one per character
    zud_ram #(
        .DEPTH (256),
        .DW    (6)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (fc_we),
        .waddr (load_char_reg),
        .wdata (acc_new[5:0]),
        .raddr (prev_reg),
        .rdata (fc_rdata)
    );

    // follower sets
    zud_ram #(
        .DEPTH (FOLLOW_DEPTH),
        .DW    (8)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (ft_we),
        .waddr ({load_char_reg, load_index_reg}),
        .wdata (acc_new),
        .raddr ({prev_reg, acc_new[5:0]}),
        .rdata (ft_rdata)
    );

    // history window
    zud_ram #(
        .DEPTH (WINDOW_SIZE),
        .DW    (8)
    ) u_hist_ram (
        .clk   (clk),
        .we    (push_fire),
        .waddr (wp_reg),
        .wdata (req.data),
        .raddr (src_reg),
        .rdata (hist_rdata)
    );

    zud_packer #(
        .OUT_LANES (OUT_LANES)
    ) u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .ready    (pk_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== src/zud_ram.sv =====
// simple dual port memory with registered read
`default_nettype none

module zud_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 8
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [DW-1:0]            wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/zud_packer.sv =====
// collects decoded bytes into lanes and holds the output register
`default_nettype none

module zud_packer #(
    parameter int OUT_LANES = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  zud_pkg::pk_req_t req,
    output logic             ready,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [71:0]      m_tdata,   // byte0..byte7, byte_count, zero pad
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // stream_done
);
    import zud_pkg::*;

    localparam int LANES = (OUT_LANES > MAX_LANES) ? MAX_LANES :
                           ((OUT_LANES < 1) ? 1 : OUT_LANES);
    localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [3:0] LANES_C = 4'(LANES);

    logic [MAX_LANES-1:0][7:0] buf_reg, buf_next;
    logic [3:0]                bcnt_reg, bcnt_next;
    logic [MAX_LANES-1:0][7:0] obytes_reg, obytes_next;
    logic [3:0]                ocnt_reg, ocnt_next;
    logic                      ovalid_reg, ovalid_next;
    logic                      olast_reg, olast_next;
    logic                      odone_reg, odone_next;
    logic                      out_free;

    assign out_free = !ovalid_reg || m_tready;

    // a full buffer or a final flush needs the output register free
    always_comb
    begin
        if (req.flush)
            ready = (bcnt_reg == 4'd0) || out_free;
        else
            ready = (bcnt_reg < LANES_C) || out_free;
    end

    always_comb
    begin
        buf_next    = buf_reg;
        bcnt_next   = bcnt_reg;
        obytes_next = obytes_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        odone_next  = odone_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (req.push && ready) begin
            if (bcnt_reg == LANES_C) begin
                obytes_next = buf_reg;
                ocnt_next   = bcnt_reg;
                olast_next  = 1'b0;
                odone_next  = 1'b0;
                ovalid_next = 1'b1;
                buf_next    = '0;
                buf_next[0] = req.data;
                bcnt_next   = 4'd1;
            end else begin
                buf_next[bcnt_reg[IW-1:0]] = req.data;
                bcnt_next = bcnt_reg + 4'd1;
            end
        end else if (req.flush && ready && (bcnt_reg != 4'd0)) begin
            obytes_next = buf_reg;
            ocnt_next   = bcnt_reg;
            olast_next  = 1'b1;
            odone_next  = req.done;
            ovalid_next = 1'b1;
            buf_next    = '0;
            bcnt_next   = 4'd0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bcnt_reg   <= 4'd0;
            ovalid_reg <= 1'b0;
            buf_reg    <= '0;
        end else begin
            bcnt_reg   <= bcnt_next;
            ovalid_reg <= ovalid_next;
            buf_reg    <= buf_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        obytes_reg <= obytes_next;
        ocnt_reg   <= ocnt_next;
        olast_reg  <= olast_next;
        odone_reg  <= odone_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'b0000, ocnt_reg, obytes_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = odone_reg;

endmodule

`default_nettype wire

// ===== dv/zud_checker.sv =====
// checker for the zip reduce decoder: watches both channels, predicts and compares
`default_nettype none

module zud_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [71:0] m_tdata,
    input  wire         m_tlast,
    input  wire         m_tuser,
    input  wire         cfg_we,
    input  wire         cfg_addr,
    input  wire  [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    import zud_pkg::*;

    typedef struct {
        logic [7:0] lane [8];
        logic [3:0] cnt;
        logic       last;
        logic       done;
    } out_word_t;

    out_word_t out_q [$];
    logic [7:0] run_q [$];

    // shadow registers and decoder state
    logic [2:0]  factor_reg;
    logic [31:0] size_reg;
    phase_t      ph;
    logic [7:0]  ld_char;
    logic [7:0]  ld_idx;
    logic [7:0]  acc;
    logic [3:0]  nbits;
    logic [1:0]  sym_ph;
    logic [7:0]  prev;
    logic [1:0]  xst;
    logic [7:0]  code;
    logic [15:0] mlen;
    logic [13:0] wpos;
    logic        first;
    logic [31:0] left;
    logic [5:0]  fol_cnt [256];
    logic [7:0]  fol_tab [16384];
    logic [7:0]  hist [16384];

    function automatic int eff_factor();
        if (factor_reg == 3'd0)
            return 1;
        if (factor_reg > 3'd4)
            return 4;
        return int'(factor_reg);
    endfunction

    function automatic logic [7:0] len_limit(int f);
        case (f)
            1:       return 8'h7f;
            2:       return 8'h3f;
            3:       return 8'h1f;
            default: return 8'h0f;
        endcase
    endfunction

    function automatic int idx_width(int cnt);
        int b;
        b = 1;
        while (b < 8 && (1 << b) < cnt)
            b++;
        return b;
    endfunction

    task automatic new_stream();
        ph = PH_COUNT;
        ld_char = 8'd255;
        ld_idx = 0;
        acc = 0;
        nbits = 0;
        sym_ph = 0;
        prev = 0;
        xst = 0;
        code = 0;
        mlen = 0;
        wpos = 0;
        first = 1'b1;
    endtask

    task automatic emit_byte(logic [7:0] b);
        if (left == 0)
            return;
        hist[wpos] = b;
        if (wpos == 14'h3fff)
            first = 1'b0;
        wpos = wpos + 14'd1;
        left = left - 1;
        run_q.push_back(b);
        if (left == 0)
            ph = PH_DONE;
    endtask

    task automatic next_char();
        if (ld_char == 0)
            ph = (left == 0) ? PH_DONE : PH_DECODE;
        else
        begin
            ld_char = ld_char - 8'd1;
            ph = PH_COUNT;
        end
    endtask

    function automatic logic shift_in(logic b, int need);
        acc = acc | (8'(b) << nbits[2:0]);
        nbits = nbits + 4'd1;
        return int'(nbits) >= need;
    endfunction

    // dle expander and window copy
    task automatic expand_sym(logic [7:0] sym);
        int f;
        int sh;
        logic [12:0] cp_dist;
        logic [13:0] src;
        int n;
        f = eff_factor();
        case (xst)
            2'd0:
            begin
                if (sym != DLE_CODE)
                    emit_byte(sym);
                else
                    xst = 2'd1;
            end
            2'd1:
            begin
                if (sym != 0)
                begin
                    code = sym;
                    mlen = 16'(sym & len_limit(f));
                    xst = (mlen == 16'(len_limit(f))) ? 2'd2 : 2'd3;
                end
                else
                begin
                    emit_byte(DLE_CODE);
                    xst = 2'd0;
                end
            end
            2'd2:
            begin
                mlen = mlen + 16'(sym);
                xst = 2'd3;
            end
            default:
            begin
                sh = 8 - f;
                cp_dist = 13'({4'(code >> sh) & 4'((1 << f) - 1), sym}) + 13'd1;
                n = int'(mlen) + 3;
                src = wpos - 14'(cp_dist);
                for (int i = 0; i < n && left != 0; i++)
                begin
                    emit_byte((first && wpos <= src) ? 8'd0 : hist[src]);
                    src = src + 14'd1;
                end
                xst = 2'd0;
            end
        endcase
        prev = sym;
    endtask

    // one input bit through the decoder, results appended to out_q
    task automatic decode_bit(logic b, logic rs);
        int cnt;
        int nres;
        logic use_bit;
        logic [7:0] sym;
        out_word_t w;
        run_q.delete();
        if (rs)
        begin
            new_stream();
            left = size_reg;
        end
        case (ph)
            PH_COUNT:
            begin
                if (shift_in(b, 6))
                begin
                    fol_cnt[ld_char] = acc[5:0];
                    acc = 0;
                    nbits = 0;
                    if (acc[5:0] == 0 && fol_cnt[ld_char] == 0)
                        next_char();
                    else
                    begin
                        ld_idx = 0;
                        ph = PH_FOLLOW;
                    end
                end
            end
            PH_FOLLOW:
            begin
                if (shift_in(b, 8))
                begin
                    fol_tab[{ld_char, ld_idx[5:0]}] = acc;
                    acc = 0;
                    nbits = 0;
                    ld_idx = ld_idx + 8'd1;
                    if (ld_idx >= 8'(fol_cnt[ld_char]))
                        next_char();
                end
            end
            PH_DECODE:
            begin
                cnt = int'(fol_cnt[prev]);
                use_bit = 1'b1;
                if (sym_ph == 0)
                begin
                    if (cnt == 0)
                        sym_ph = 2'd1;
                    else
                    begin
                        sym_ph = b ? 2'd1 : 2'd2;
                        use_bit = 1'b0;
                    end
                end
                if (use_bit && shift_in(b, (sym_ph == 2'd1) ? 8 : idx_width(cnt)))
                begin
                    sym = (sym_ph == 2'd1) ? acc : fol_tab[{prev, acc[5:0]}];
                    acc = 0;
                    nbits = 0;
                    sym_ph = 0;
                    expand_sym(sym);
                end
            end
            default: ;
        endcase
        // pack into lane-wide results
        nres = (run_q.size() + 7) / 8;
        for (int k = 0; k < nres; k++)
        begin
            w.cnt = 0;
            for (int j = 0; j < 8; j++)
            begin
                w.lane[j] = 8'd0;
                if (run_q.size() != 0)
                begin
                    w.lane[j] = run_q.pop_front();
                    w.cnt = w.cnt + 4'd1;
                end
            end
            w.last = (k == nres - 1);
            w.done = (k == nres - 1) && (left == 0);
            out_q.push_back(w);
        end
    endtask

    task automatic check_word();
        out_word_t w;
        if (out_q.size() == 0)
        begin
            $error("output transfer with nothing expected: tdata=%h", m_tdata);
            errors++;
            return;
        end
        w = out_q.pop_front();
        for (int j = 0; j < 8; j++)
        begin
            if (m_tdata[8*j +: 8] !== w.lane[j])
            begin
                $error("byte%0d: expected %h, got %h", j, w.lane[j], m_tdata[8*j +: 8]);
                errors++;
            end
        end
        if (m_tdata[67:64] !== w.cnt)
        begin
            $error("byte_count: expected %0d, got %0d", w.cnt, m_tdata[67:64]);
            errors++;
        end
        if (m_tlast !== w.last)
        begin
            $error("run_last: expected %b, got %b", w.last, m_tlast);
            errors++;
        end
        if (m_tuser !== w.done)
        begin
            $error("stream_done: expected %b, got %b", w.done, m_tuser);
            errors++;
        end
    endtask

    // reset state, then follow every transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            factor_reg = 3'd1;
            size_reg = 0;
            left = 0;
            new_stream();
            out_q.delete();
            pending = 0;
            for (int i = 0; i < 256; i++)
                fol_cnt[i] = 0;
            for (int i = 0; i < 16384; i++)
            begin
                fol_tab[i] = 0;
                hist[i] = 0;
            end
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word();
            if (s_tvalid && s_tready)
                decode_bit(s_tdata[0], s_tuser);
            if (cfg_we)
            begin
                if (cfg_addr == CFG_FACTOR)
                    factor_reg = cfg_data[2:0];
                else
                    size_reg = cfg_data;
            end
            pending = out_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/zip_unreduce_decoder_top_test.sv =====
// testbench top for the zip reduce decoder: stream generation and verdict
`default_nettype none

module zip_unreduce_decoder_top_test;
    import zud_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_addr;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    int          burst_left;

    // follower sets as written into the current stream
    int          set_cnt [256];
    logic [7:0]  set_val [256][64];
    logic [7:0]  last_sym;
    int          cur_factor;

    zip_unreduce_decoder_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    zud_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // clock
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("zip_unreduce_decoder_top: mismatch");
            $finish;
        end
    end

    // receiver stalls, with one long hold-off so the block backs up
    initial
    begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(3);
            len = $urandom_range(300, 10);
            for (int i = 0; i < len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(1));
                    2:       m_tready = ($urandom_range(7) == 0);
                    default: m_tready = ($urandom_range(7) != 0);
                endcase
            end
            // hold off only while results are flowing, so the block fills up
            if (!held && m_tvalid && cycles > 15000)
            begin
                held = 1'b1;
                @(negedge clk);
                m_tready = 1'b0;
                repeat (800) @(negedge clk);
            end
        end
    end

    task automatic cfg_write(logic a, logic [31:0] d);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_data = d;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one bit transfer, sender may idle between bursts
    task automatic send_bit(logic b, logic rs);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(60, 1);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'd0, b};
        s_tuser = rs;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_val(logic [7:0] v, int n);
        for (int i = 0; i < n; i++)
            send_bit(v[i], 1'b0);
    endtask

    // wait for the block to drain before touching registers
    task automatic wait_drain();
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic int idx_width(int cnt);
        int b;
        b = 1;
        while (b < 8 && (1 << b) < cnt)
            b++;
        return b;
    endfunction

    // encode one symbol, through the follower set when allowed
    task automatic send_sym(logic [7:0] sym, bit via_set);
        int c;
        int hit;
        c = set_cnt[last_sym];
        hit = -1;
        if (c != 0)
        begin
            for (int i = 0; i < c; i++)
                if (hit < 0 && set_val[last_sym][i] == sym)
                    hit = i;
            if (hit >= 0 && via_set)
            begin
                send_bit(1'b0, 1'b0);
                send_val(8'(hit), idx_width(c));
            end
            else
            begin
                send_bit(1'b1, 1'b0);
                send_val(sym, 8);
            end
        end
        else
            send_val(sym, 8);
        last_sym = sym;
    endtask

    // dle sequence for a window copy; the code field must stay nonzero
    task automatic send_copy(int lenpart, int hi, logic [7:0] lo, logic [7:0] ext);
        logic [7:0] c;
        int lm;
        lm = (1 << (8 - cur_factor)) - 1;
        c = 8'(lenpart | (hi << (8 - cur_factor)));
        if (c == 0)
            c = 8'd1;
        send_sym(DLE_CODE, 1'($urandom_range(1)));
        send_sym(c, 1'($urandom_range(1)));
        if ((c & 8'(lm)) == 8'(lm))
            send_sym(ext, 1'($urandom_range(1)));
        send_sym(lo, 1'($urandom_range(1)));
    endtask

    // follower tables; first bit carries the restart
    task automatic send_tables(int nsets);
        int ch;
        for (int i = 0; i < 256; i++)
            set_cnt[i] = 0;
        set_cnt[0] = $urandom_range(63, 1);
        for (int i = 0; i < nsets; i++)
        begin
            ch = $urandom_range(255);
            case ($urandom_range(3))
                0:       set_cnt[ch] = 1;
                1:       set_cnt[ch] = 63;
                default: set_cnt[ch] = $urandom_range(63, 1);
            endcase
        end
        for (int i = 0; i < 256; i++)
            for (int j = 0; j < 64; j++)
                set_val[i][j] = 8'($urandom_range(255));
        for (int ch2 = 255; ch2 >= 0; ch2--)
        begin
            for (int i = 0; i < 6; i++)
                send_bit(1'(set_cnt[ch2] >> i), ch2 == 255 && i == 0);
            for (int j = 0; j < set_cnt[ch2]; j++)
                send_val(set_val[ch2][j], 8);
        end
        last_sym = 8'd0;
    endtask

    // random symbol stream; long mode favors maximal copies
    task automatic send_symbols(int nsym, bit long_mode);
        int r;
        int lm;
        lm = (1 << (8 - cur_factor)) - 1;
        for (int i = 0; i < nsym; i++)
        begin
            r = $urandom_range(99);
            if (long_mode && r < 85)
                send_copy(lm, $urandom_range((1 << cur_factor) - 1),
                          8'($urandom_range(255)), 8'd255);
            else if (r < 45)
            begin
                if (set_cnt[last_sym] != 0 && $urandom_range(1))
                    send_sym(set_val[last_sym][$urandom_range(set_cnt[last_sym] - 1)], 1'b1);
                else
                    send_sym(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (r < 55)
            begin
                send_sym(DLE_CODE, 1'b0);
                send_sym(8'd0, 1'b0);
            end
            else
                send_copy($urandom_range(lm), $urandom_range((1 << cur_factor) - 1),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic new_settings(int f, logic [31:0] sz);
        wait_drain();
        cfg_write(CFG_FACTOR, 32'(f));
        cfg_write(CFG_OUT_SIZE, sz);
        cur_factor = (f < 1) ? 1 : (f > 4) ? 4 : f;
    endtask

    // stimulus
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_FACTOR;
        cfg_data = 32'd0;
        burst_left = 0;
        cur_factor = 1;
        last_sym = 8'd0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bits before any restart: tables load, nothing comes out
        for (int i = 0; i < 24; i++)
            send_bit(1'($urandom_range(1)), 1'b0);

        // directed stream: set lookups, literals, dle escape, copies, clipping
        new_settings(1, 32'd90);
        for (int i = 0; i < 256; i++)
            set_cnt[i] = 0;
        set_cnt[0] = 1;
        set_cnt[8'h41] = 63;
        set_cnt[255] = 2;
        for (int i = 0; i < 256; i++)
            for (int j = 0; j < 64; j++)
                set_val[i][j] = 8'(i + j);
        set_val[0][0] = 8'h41;
        set_val[8'h41][62] = 8'hff;
        set_val[255][1] = 8'h00;
        for (int ch = 255; ch >= 0; ch--)
        begin
            for (int i = 0; i < 6; i++)
                send_bit(1'(set_cnt[ch] >> i), ch == 255 && i == 0);
            for (int j = 0; j < set_cnt[ch]; j++)
                send_val(set_val[ch][j], 8);
        end
        last_sym = 8'd0;
        send_sym(8'h41, 1'b1);
        send_sym(8'hff, 1'b1);
        send_sym(8'h00, 1'b1);
        send_sym(8'hff, 1'b0);
        send_sym(8'h00, 1'b0);
        send_sym(DLE_CODE, 1'b0);
        send_sym(8'h00, 1'b0);
        send_copy(1, 0, 8'd0, 8'd0);
        send_copy(2, 1, 8'd255, 8'd0);
        send_copy(127, 0, 8'd2, 8'd255);
        for (int i = 0; i < 20; i++)
            send_bit(1'($urandom_range(1)), 1'b0);

        // zero length stream, factor zero acting as one
        new_settings(0, 32'd0);
        send_tables(3);
        for (int i = 0; i < 16; i++)
            send_bit(1'($urandom_range(1)), 1'b0);

        // restart cut short inside the table load, then a full stream
        new_settings(2, 32'd300);
        for (int i = 0; i < 40; i++)
            send_bit(1'($urandom_range(1)), i == 0);
        send_tables(10);
        send_symbols(60, 0);

        // random streams over legal factors 3 and 4 and folded factors 5 and 7
        for (int f = 3; f <= 7; f++)
        begin
            if (f == 6)
                continue;
            new_settings(f, $urandom_range(700, 100));
            send_tables($urandom_range(12, 2));
            send_symbols(70, 0);
        end

        // long stream past the window size, long copies
        new_settings(1, 32'd17000);
        send_tables(6);
        send_symbols(80, 1);

        // largest output size, left unfinished
        new_settings(4, 32'hffffffff);
        send_tables(4);
        send_symbols(30, 0);

        // drain and give the verdict
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("zip_unreduce_decoder_top: match");
        else
            $display("zip_unreduce_decoder_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
